[rtl/ktfe_pkg.sv]
`timescale 1ns / 1ps

package ktfe_pkg;

   localparam int KEY_WIDTH   = 48;
   localparam int FIELD_WIDTH = 64;

   typedef enum logic [1:0] {
      KIND_UPDATE = 2'd0,
      KIND_QUERY  = 2'd1,
      KIND_CLEAR  = 2'd2
   } ktfe_kind_type;

   typedef enum logic {
      STATUS_OK        = 1'b0,
      STATUS_NOT_FOUND = 1'b1
   } ktfe_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_INSERT,
      ST_FINISH
   } ktfe_state_type;

   typedef struct packed {
      logic [1:0]             kind;
      logic [KEY_WIDTH-1:0]   device_address;
      logic [FIELD_WIDTH-1:0] payload_in;
   } ktfe_req_type;

   typedef struct packed {
      logic                   status;
      logic [FIELD_WIDTH-1:0] payload_out;
   } ktfe_rsp_type;

   // Lookup token that walks the cell chain, one cell per cycle
   typedef struct packed {
      logic act;
      logic hit;
   } ktfe_tok_type;

   // Control broadcast to every cell
   typedef struct packed {
      logic                 is_update;
      logic                 shift;
      logic [KEY_WIDTH-1:0] key;
   } ktfe_bcast_type;

endpackage

[rtl/ktfe_cell.sv]
`timescale 1ns / 1ps

module ktfe_cell #(
   parameter int PAYLOAD_WIDTH = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ktfe_pkg::ktfe_bcast_type          bcast,
   input  logic [PAYLOAD_WIDTH-1:0]          wr_data,
   input  logic                              used,
   input  ktfe_pkg::ktfe_tok_type            tok_i,
   input  logic [PAYLOAD_WIDTH-1:0]          tok_data_i,
   output ktfe_pkg::ktfe_tok_type            tok_o,
   output logic [PAYLOAD_WIDTH-1:0]          tok_data_o,
   input  logic [ktfe_pkg::KEY_WIDTH-1:0]    prev_key,
   input  logic [PAYLOAD_WIDTH-1:0]          prev_data,
   output logic [ktfe_pkg::KEY_WIDTH-1:0]    ent_key,
   output logic [PAYLOAD_WIDTH-1:0]          ent_data
);

   logic [ktfe_pkg::KEY_WIDTH-1:0] key_ff, key_in;
   logic [PAYLOAD_WIDTH-1:0]       data_ff, data_in;
   ktfe_pkg::ktfe_tok_type         tok_ff, tok_in;
   logic [PAYLOAD_WIDTH-1:0]       tok_data_ff, tok_data_in;
   logic                           match;

   assign match = tok_i.act && used && (key_ff == bcast.key);

   always_comb begin
      tok_in.act  = tok_i.act;
      tok_in.hit  = tok_i.hit | match;
      tok_data_in = match ? data_ff : tok_data_i;
      key_in      = key_ff;
      data_in     = data_ff;
      // shift inserts a new entry at the head, aging every entry by one place
      if (bcast.shift) begin
         key_in  = prev_key;
         data_in = prev_data;
      end else if (match && bcast.is_update) begin
         data_in = wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.act <= 1'b0;
      end else begin
         tok_ff.act <= tok_in.act;
      end
      tok_ff.hit  <= tok_in.hit;
      tok_data_ff <= tok_data_in;
      key_ff      <= key_in;
      data_ff     <= data_in;
   end

   assign tok_o      = tok_ff;
   assign tok_data_o = tok_data_ff;
   assign ent_key    = key_ff;
   assign ent_data   = data_ff;

endmodule

[rtl/keyed_table_fifo_evict_core.sv]
`timescale 1ns / 1ps

// Keyed table with oldest-first replacement, built as a chain of cells.
// Input channel req_*: one item per handshake (req_valid high, req_stall low).
//   kind update stores the payload under device_address (in place if the key
//   is present, else appended, evicting the oldest entry when full); kind
//   query looks up device_address; kind clear empties the table.
// Result channel rsp_*: exactly one item per request, in request order.
//   status is not-found only for a query miss; payload_out carries the hit
//   payload of a query and is zero otherwise.
// Cell 0 holds the newest entry, cell occupancy-1 the oldest. A lookup token
// walks the chain one cell per cycle. An update or query item goes from
// search to result, with an insert step between for an append; clear and
// unused kinds go straight to the result. The token walk through the cell
// chain sets the pace; one item is worked on at a time and req_stall is high
// while busy.
// The result sits in an output register: while the receiver stalls it holds
// steady, and the next item is still accepted and searched, waiting only at
// the end for the register to free up.
// Reset empties the table at once; stored keys need no clearing pass.

module keyed_table_fifo_evict_core #(
   parameter int TABLE_DEPTH   = 40,
   parameter int PAYLOAD_WIDTH = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  ktfe_pkg::ktfe_req_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output ktfe_pkg::ktfe_rsp_type rsp_item
);

   localparam int OCC_W = $clog2(TABLE_DEPTH + 1);

   ktfe_pkg::ktfe_state_type         state_ff, state_in;
   logic [1:0]                       kind_ff, kind_in;
   logic [ktfe_pkg::KEY_WIDTH-1:0]   key_ff, key_in;
   logic [PAYLOAD_WIDTH-1:0]         pay_ff, pay_in;
   logic                             start_ff, start_in;
   logic [OCC_W-1:0]                 occ_ff, occ_in;
   logic                             res_status_ff, res_status_in;
   logic [ktfe_pkg::FIELD_WIDTH-1:0] res_data_ff, res_data_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   ktfe_pkg::ktfe_rsp_type           rsp_item_ff, rsp_item_in;
   logic                             shift;

   ktfe_pkg::ktfe_bcast_type         bcast;
   ktfe_pkg::ktfe_tok_type           tok   [TABLE_DEPTH+1];
   logic [PAYLOAD_WIDTH-1:0]         tok_data [TABLE_DEPTH+1];
   logic [ktfe_pkg::KEY_WIDTH-1:0]   ent_key  [TABLE_DEPTH];
   logic [PAYLOAD_WIDTH-1:0]         ent_data [TABLE_DEPTH];

   // inject the token at the head of the chain for one cycle
   assign tok[0].act  = start_ff;
   assign tok[0].hit  = 1'b0;
   assign tok_data[0] = '0;

   assign bcast.is_update = (kind_ff == ktfe_pkg::KIND_UPDATE);
   assign bcast.shift     = shift;
   assign bcast.key       = key_ff;

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      logic [ktfe_pkg::KEY_WIDTH-1:0] prev_key;
      logic [PAYLOAD_WIDTH-1:0]       prev_data;
      logic                           used;

      if (i == 0) begin : g_head
         assign prev_key  = key_ff;
         assign prev_data = pay_ff;
      end else begin : g_body
         assign prev_key  = ent_key[i-1];
         assign prev_data = ent_data[i-1];
      end

      assign used = (occ_ff > OCC_W'(i));

      ktfe_cell #(
         .PAYLOAD_WIDTH(PAYLOAD_WIDTH)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .bcast      (bcast),
         .wr_data    (pay_ff),
         .used       (used),
         .tok_i      (tok[i]),
         .tok_data_i (tok_data[i]),
         .tok_o      (tok[i+1]),
         .tok_data_o (tok_data[i+1]),
         .prev_key   (prev_key),
         .prev_data  (prev_data),
         .ent_key    (ent_key[i]),
         .ent_data   (ent_data[i])
      );
   end

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      key_in        = key_ff;
      pay_in        = pay_ff;
      start_in      = 1'b0;
      occ_in        = occ_ff;
      res_status_in = res_status_ff;
      res_data_in   = res_data_ff;
      rsp_item_in   = rsp_item_ff;
      // drop the result once the receiver takes it
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      shift         = 1'b0;
      req_stall     = (state_ff != ktfe_pkg::ST_IDLE);

      unique case (state_ff)
         ktfe_pkg::ST_IDLE: begin
            if (req_valid) begin
               kind_in       = req_item.kind;
               key_in        = req_item.device_address;
               pay_in        = req_item.payload_in[PAYLOAD_WIDTH-1:0];
               res_status_in = ktfe_pkg::STATUS_OK;
               res_data_in   = '0;
               unique case (req_item.kind)
                  ktfe_pkg::KIND_UPDATE,
                  ktfe_pkg::KIND_QUERY: begin
                     start_in = 1'b1;
                     state_in = ktfe_pkg::ST_SEARCH;
                  end
                  ktfe_pkg::KIND_CLEAR: begin
                     occ_in   = '0;
                     state_in = ktfe_pkg::ST_FINISH;
                  end
                  default: begin
                     state_in = ktfe_pkg::ST_FINISH;
                  end
               endcase
            end
         end
         ktfe_pkg::ST_SEARCH: begin
            // wait for the token to leave the tail cell
            if (tok[TABLE_DEPTH].act) begin
               if (kind_ff == ktfe_pkg::KIND_QUERY) begin
                  res_status_in = tok[TABLE_DEPTH].hit ? ktfe_pkg::STATUS_OK
                                                       : ktfe_pkg::STATUS_NOT_FOUND;
                  res_data_in   = tok[TABLE_DEPTH].hit
                                ? ktfe_pkg::FIELD_WIDTH'(tok_data[TABLE_DEPTH]) : '0;
                  state_in      = ktfe_pkg::ST_FINISH;
               end else if (tok[TABLE_DEPTH].hit) begin
                  state_in = ktfe_pkg::ST_FINISH;
               end else begin
                  state_in = ktfe_pkg::ST_INSERT;
               end
            end
         end
         ktfe_pkg::ST_INSERT: begin
            // append at the head; a full table loses its tail (oldest) entry
            shift = 1'b1;
            if (occ_ff != OCC_W'(TABLE_DEPTH)) begin
               occ_in = occ_ff + OCC_W'(1);
            end
            state_in = ktfe_pkg::ST_FINISH;
         end
         ktfe_pkg::ST_FINISH: begin
            // hand over once the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_item_in.status      = res_status_ff;
               rsp_item_in.payload_out = res_data_ff;
               rsp_valid_in            = 1'b1;
               state_in                = ktfe_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ktfe_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ktfe_pkg::ST_IDLE;
         start_ff     <= 1'b0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff       <= kind_in;
      key_ff        <= key_in;
      pay_ff        <= pay_in;
      res_status_ff <= res_status_in;
      res_data_ff   <= res_data_in;
      rsp_item_ff   <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule
